/* rtl/core/ip_address_text_parser_top_assert.svh */
// Assertion macros for the address text parser blocks.
// Expects clk and arst_n in the scope of each use.
`ifndef IP_ADDRESS_TEXT_PARSER_TOP_ASSERT_SVH
`define IP_ADDRESS_TEXT_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define IPP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ip parser: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define IPP_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ip parser: next-cycle check failed");

`endif

/* rtl/core/ipp_pkg.sv */
// Shared types and constants for the address text parser.
// No dependencies; imported by every module of the block.
package ipp_pkg;

	// Address families as given on the first request of a string
	localparam logic [1:0] FAM_V4 = 2'd0;
	localparam logic [1:0] FAM_V6 = 2'd1;

	// Characters of interest
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;

	localparam logic [11:0] OCTET_MAX  = 12'd255;
	localparam logic [4:0]  ADDR_BYTES = 5'd16;

	typedef enum logic [2:0] {
		PH_START,
		PH_V4,
		PH_LEAD,
		PH_V6,
		PH_V6COLON,
		PH_TAIL
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_MALFORMED,
		ST_UNSUPPORTED
	} status_t;

	typedef struct packed {
		logic [0:15][7:0] bytes;
		logic [4:0]       write_pos;
		logic [4:0]       gap_pos;
		logic             gap_seen;
		logic [15:0]      group_value;
		logic [2:0]       group_digits;
		logic [7:0]       token_octet;
		logic             token_not_decimal;
		phase_t           phase;
		logic [2:0]       octet_count;
		logic             octet_has_digit;
		logic             failed;
		logic [1:0]       family;
		logic             text_done;
	} ipp_state_t;

	localparam ipp_state_t STATE_CLEAR = '0;

endpackage

/* rtl/core/ipp_char_step.sv */
// Per-character update of the parser state.
// Depends on ipp_pkg.
module ipp_char_step (
	input  ipp_pkg::ipp_state_t cur,
	input  logic                first,
	input  logic [1:0]          mode,
	input  logic [7:0]          text_byte,
	output ipp_pkg::ipp_state_t nxt
);
	import ipp_pkg::*;

	logic [1:0]  fam;
	logic        unsup;
	logic        is_dig;
	logic        is_hex;
	logic [3:0]  hv;
	logic [11:0] sum;
	logic [4:0]  base;
	logic [4:0]  v4_idx;
	logic [3:0]  wp4;

	assign fam    = first ? mode : cur.family;
	assign unsup  = (fam != FAM_V4) && (fam != FAM_V6);
	assign is_dig = (text_byte >= CH_0) && (text_byte <= CH_9);
	assign is_hex = is_dig || ((text_byte >= CH_LA) && (text_byte <= CH_LF))
		|| ((text_byte >= CH_UA) && (text_byte <= CH_UF));
	// letters a-f / A-F have low nibble 1..6
	assign hv     = is_dig ? text_byte[3:0] : text_byte[3:0] + 4'd9;
	assign sum    = 12'({cur.token_octet, 3'b000}) + 12'({cur.token_octet, 1'b0}) + 12'(hv);
	assign base   = (fam == FAM_V4) ? 5'd0 : cur.write_pos;
	assign v4_idx = base + 5'(cur.octet_count) - 5'd1;
	assign wp4    = cur.write_pos[3:0];

	always_comb begin
		nxt = cur;
		nxt.family = fam;
		if (!(cur.text_done || cur.failed || unsup)) begin
			if (text_byte == CH_NUL) begin
				nxt.text_done = 1'b1;
			end else if (fam == FAM_V4 || cur.phase == PH_TAIL) begin
				// dotted-quad octet
				if (is_dig) begin
					if ((cur.octet_has_digit && cur.token_octet == 8'd0) || sum > OCTET_MAX) begin
						nxt.failed = 1'b1;
					end else begin
						nxt.token_octet = sum[7:0];
						if (!cur.octet_has_digit) begin
							nxt.octet_count = cur.octet_count + 3'd1;
							if (cur.octet_count >= 3'd4) begin
								nxt.failed = 1'b1;
							end else begin
								nxt.octet_has_digit = 1'b1;
							end
						end
					end
				end else if (text_byte == CH_DOT && cur.octet_has_digit) begin
					if (cur.octet_count == 3'd4) begin
						nxt.failed = 1'b1;
					end else begin
						nxt.bytes[v4_idx[3:0]] = cur.token_octet;
						nxt.token_octet = 8'd0;
						nxt.octet_has_digit = 1'b0;
					end
				end else begin
					nxt.failed = 1'b1;
				end
			end else if (cur.phase == PH_START && text_byte == CH_COLON) begin
				nxt.phase = PH_LEAD;
			end else if (cur.phase == PH_LEAD && text_byte != CH_COLON) begin
				nxt.failed = 1'b1;
			end else if (is_hex) begin
				nxt.phase = PH_V6;
				if (hv > 4'd9) begin
					nxt.token_not_decimal = 1'b1;
				end else if (!cur.token_not_decimal) begin
					if ((cur.group_digits != 3'd0 && cur.token_octet == 8'd0) || sum > OCTET_MAX) begin
						nxt.token_not_decimal = 1'b1;
					end else begin
						nxt.token_octet = sum[7:0];
					end
				end
				nxt.group_value = {cur.group_value[11:0], hv};
				nxt.group_digits = cur.group_digits + 3'd1;
				if (cur.group_digits >= 3'd4) begin
					nxt.failed = 1'b1;
				end
			end else if (text_byte == CH_COLON) begin
				if (cur.group_digits == 3'd0) begin
					// second colon of a gap
					if (cur.gap_seen) begin
						nxt.failed = 1'b1;
					end else begin
						nxt.gap_seen = 1'b1;
						nxt.gap_pos = cur.write_pos;
						nxt.phase = PH_V6;
					end
				end else if (cur.write_pos > 5'd14) begin
					nxt.failed = 1'b1;
				end else begin
					nxt.bytes[wp4] = cur.group_value[15:8];
					nxt.bytes[wp4 + 4'd1] = cur.group_value[7:0];
					nxt.write_pos = cur.write_pos + 5'd2;
					nxt.group_value = 16'd0;
					nxt.group_digits = 3'd0;
					nxt.token_octet = 8'd0;
					nxt.token_not_decimal = 1'b0;
					nxt.phase = PH_V6COLON;
				end
			end else if (text_byte == CH_DOT && cur.write_pos <= 5'd12
				&& cur.group_digits != 3'd0 && !cur.token_not_decimal) begin
				// group just read becomes the first octet of an IPv4 tail
				nxt.bytes[wp4] = cur.token_octet;
				nxt.token_octet = 8'd0;
				nxt.octet_count = 3'd1;
				nxt.octet_has_digit = 1'b0;
				nxt.group_value = 16'd0;
				nxt.group_digits = 3'd0;
				nxt.phase = PH_TAIL;
			end else begin
				nxt.failed = 1'b1;
			end
		end
		if (nxt.phase == PH_START && fam == FAM_V4) begin
			nxt.phase = PH_V4;
		end
	end

endmodule

/* rtl/core/ipp_finish.sv */
// End-of-string checks, gap expansion and result forming.
// Depends on ipp_pkg.
module ipp_finish (
	input  ipp_pkg::ipp_state_t st,
	output ipp_pkg::status_t    status,
	output logic [63:0]         addr_high,
	output logic [63:0]         addr_low
);
	import ipp_pkg::*;

	logic [0:15][7:0] fb;
	logic [0:15][7:0] head;
	logic [0:15][7:0] tail;
	logic [127:0]     fin;
	logic [4:0]       wpf;
	logic [4:0]       sh;
	logic [7:0]       shamt;
	logic             bad;
	logic [3:0]       wp4;

	assign wp4   = st.write_pos[3:0];
	assign sh    = ADDR_BYTES - wpf;
	assign shamt = {sh, 3'b000};

	always_comb begin
		fb  = st.bytes;
		wpf = st.write_pos;
		bad = 1'b0;
		// flush the last group or tail octet
		if (st.phase == PH_LEAD || st.phase == PH_V6COLON) begin
			bad = 1'b1;
		end else if (st.phase == PH_TAIL) begin
			if (st.octet_count != 3'd4) begin
				bad = 1'b1;
			end
			fb[wp4 + 4'd3] = st.token_octet;
			wpf = st.write_pos + 5'd4;
		end else if (st.group_digits != 3'd0) begin
			if (st.write_pos > 5'd14) begin
				bad = 1'b1;
			end
			fb[wp4] = st.group_value[15:8];
			fb[wp4 + 4'd1] = st.group_value[7:0];
			wpf = st.write_pos + 5'd2;
		end
		if (st.gap_seen) begin
			if (wpf == ADDR_BYTES || st.gap_pos > wpf) begin
				bad = 1'b1;
			end
		end else if (wpf != ADDR_BYTES) begin
			bad = 1'b1;
		end
	end

	// bytes past the gap slide to the end; nothing above write_pos is nonzero
	always_comb begin
		for (int k = 0; k < 16; k++) begin
			head[k] = (5'(k) < st.gap_pos) ? fb[k] : 8'd0;
			tail[k] = (5'(k) < st.gap_pos) ? 8'd0 : fb[k];
		end
		fin = st.gap_seen ? (head | (tail >> shamt)) : fb;
	end

	always_comb begin
		status    = ST_OK;
		addr_high = 64'd0;
		addr_low  = 64'd0;
		if (st.family != FAM_V4 && st.family != FAM_V6) begin
			status = ST_UNSUPPORTED;
		end else if (st.failed) begin
			status = ST_MALFORMED;
		end else if (st.family == FAM_V4) begin
			if (st.octet_count != 3'd4) begin
				status = ST_MALFORMED;
			end else begin
				addr_low = {32'd0, st.bytes[0], st.bytes[1], st.bytes[2], st.token_octet};
			end
		end else if (bad) begin
			status = ST_MALFORMED;
		end else begin
			addr_high = fin[127:64];
			addr_low  = fin[63:0];
		end
	end

endmodule

/* rtl/core/ip_address_text_parser_top.sv */
// Streaming IPv4/IPv6 address text parser, top level; uses ipp_pkg, ipp_char_step,
// ipp_finish and the assertion macros in ip_address_text_parser_top_assert.svh.
// out_valid rises once an accepted end_of_text request moves from the input register into the
// result register, later only while an earlier result still waits in the result register.
// Throughput: one character per cycle; only a stalled result holds back an end_of_text request.
// Reset (arst_n low): parser state cleared to the start of a string, no result pending.
`include "ip_address_text_parser_top_assert.svh"
module ip_address_text_parser_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          mode,
	input  logic [7:0]          text_byte,
	input  logic                end_of_text,
	output logic                out_valid,
	input  logic                out_ready,
	output ipp_pkg::status_t    status,
	output logic [63:0]         addr_high,
	output logic [63:0]         addr_low
);
	import ipp_pkg::*;

	// Input register
	logic       valid_s1;
	logic [1:0] mode_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;

	// Parser state and first-request flag
	ipp_state_t state_q;
	ipp_state_t state_nxt;
	logic       first_q;

	// Result register
	logic        out_valid_q;
	status_t     status_q;
	logic [63:0] addr_high_q;
	logic [63:0] addr_low_q;

	status_t     fin_status;
	logic [63:0] fin_high;
	logic [63:0] fin_low;

	logic out_free;
	logic adv;

	// The result register is free when empty or being drained this cycle.
	assign out_free = !out_valid_q || out_ready;
	// A plain character always advances; an end_of_text request needs room for its result.
	assign adv      = valid_s1 && (!eot_s1 || out_free);
	// Take a new request whenever the input register empties this cycle.
	assign in_ready = !valid_s1 || adv;

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign addr_high = addr_high_q;
	assign addr_low  = addr_low_q;

	// Character update: family is latched from mode on the first request of a string.
	ipp_char_step u_step (
		.cur       (state_q),
		.first     (first_q),
		.mode      (mode_s1),
		.text_byte (byte_s1),
		.nxt       (state_nxt)
	);

	// Result forming on the state that includes the final character.
	ipp_finish u_finish (
		.st        (state_nxt),
		.status    (fin_status),
		.addr_high (fin_high),
		.addr_low  (fin_low)
	);

	// Input register: hold while stalled, load on acceptance, drop once advanced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1 <= mode;
			byte_s1 <= text_byte;
			eot_s1  <= end_of_text;
		end
	end

	// Parser state: advance per character, clear at the end of each string.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_CLEAR;
			first_q <= 1'b1;
		end else if (adv) begin
			state_q <= eot_s1 ? STATE_CLEAR : state_nxt;
			first_q <= eot_s1;
		end
	end

	// Result register: load on end_of_text, release when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && eot_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && eot_s1) begin
			status_q    <= fin_status;
			addr_high_q <= fin_high;
			addr_low_q  <= fin_low;
		end
	end

	// Error and unsupported results carry an all-zero address.
	`IPP_ASSERT_IMP(a_err_addr_zero, out_valid_q && status_q != ST_OK, (addr_high_q | addr_low_q) == 64'd0)
	// A result appears only from an end_of_text request that advanced.
	`IPP_ASSERT_IMP(a_result_from_eot, $rose(out_valid_q), $past(adv && eot_s1))
	// The end of a string restarts the parser.
	`IPP_ASSERT_NXT(a_eot_restarts, adv && eot_s1, first_q && state_q == STATE_CLEAR)
	// A blocked end_of_text request is held in the input register.
	`IPP_ASSERT_NXT(a_eot_held, valid_s1 && eot_s1 && !out_free, valid_s1 && $stable(eot_s1))

endmodule
